/* hw/rtl/rfp_pkg.sv */
// Shared types and constants for the ranging frame parser.
`default_nettype none

package rfp_pkg;

  // Frame layout.
  localparam logic [7:0] HeaderByte = 8'h59;
  localparam logic [7:0] HeaderSum  = 8'hB2;
  localparam int         BodyLen    = 6;
  localparam int         BodyIdxW   = 3;

  // Register widths and reset values.
  localparam int          HdrLimW        = 10;
  localparam int          WaitLimW       = 8;
  localparam int          CfgIdxW        = 2;
  localparam int          CfgDataW       = 10;
  localparam logic [9:0]  HdrLimReset    = 10'd32;
  localparam logic [7:0]  WaitLimReset   = 8'd10;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HDR_LIMIT  = 2'd0,
    CFG_WAIT_LIMIT = 2'd1
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_HEADER   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  // Input word: a received byte or a millisecond tick.
  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } in_item_t;

  // Result word.
  typedef struct packed {
    status_t     result_status;
    logic [15:0] distance;
    logic [15:0] strength;
    logic [15:0] temperature_code;
  } out_item_t;

  // Result handed from the parser core to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/rfp_core.sv */
// Input register, configuration registers and frame parsing state.
`default_nettype none

module rfp_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rfp_pkg::in_item_t in_data,
  input  wire logic              cfg_valid,
  input  wire logic [rfp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rfp_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic              res_take,
  output rfp_pkg::res_t          res
);
  import rfp_pkg::*;

  // Input stage.
  logic     v1_r;
  in_item_t item1_r;
  logic     adv;
  logic     accept;

  // Configuration.
  logic [HdrLimW-1:0]  hdr_lim_r;
  logic [WaitLimW-1:0] wait_lim_r;

  // Parser state.
  logic                in_frame_r, in_frame_nxt;
  logic [7:0]          prev_r, prev_nxt;
  logic [HdrLimW-1:0]  miss_r, miss_nxt;
  logic [BodyIdxW-1:0] idx_r, idx_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          idle_r, idle_nxt;
  logic [7:0]          body_r [BodyLen];
  logic                body_we;

  logic       emit;
  status_t    status;
  logic [7:0] idle_inc;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_lim_r  <= HdrLimReset;
      wait_lim_r <= WaitLimReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HDR_LIMIT:  hdr_lim_r  <= cfg_wdata;
        CFG_WAIT_LIMIT: wait_lim_r <= cfg_wdata[WaitLimW-1:0];
        default: ;
      endcase
    end
  end

  // Step logic for the word held in the input stage.
  assign idle_inc = idle_r + 8'd1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    miss_nxt     = miss_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    idle_nxt     = idle_r;
    body_we      = 1'b0;
    emit         = 1'b0;
    status       = ST_OK;
    if (item1_r.mode) begin
      idle_nxt = idle_inc;
      if (idle_inc >= wait_lim_r) begin
        emit   = 1'b1;
        status = ST_TIMEOUT;
      end
    end else begin
      idle_nxt = '0;
      if (!in_frame_r) begin
        if (prev_r == HeaderByte && item1_r.byte_value == HeaderByte) begin
          in_frame_nxt = 1'b1;
          idx_nxt      = '0;
          sum_nxt      = HeaderSum;
        end else begin
          prev_nxt = item1_r.byte_value;
          if (miss_r >= hdr_lim_r) begin
            emit   = 1'b1;
            status = ST_HEADER;
          end else begin
            miss_nxt = miss_r + 10'd1;
          end
        end
      end else if (idx_r < BodyIdxW'(BodyLen)) begin
        body_we = 1'b1;
        sum_nxt = sum_r + item1_r.byte_value;
        idx_nxt = idx_r + 3'd1;
      end else begin
        emit   = 1'b1;
        status = (sum_r == item1_r.byte_value) ? ST_OK : ST_CHECKSUM;
      end
    end
    // Any result sends the parser back to the hunt.
    if (emit) begin
      in_frame_nxt = 1'b0;
      prev_nxt     = '0;
      miss_nxt     = '0;
      idx_nxt      = '0;
      sum_nxt      = '0;
      idle_nxt     = '0;
    end
  end

  // Result word; data fields are zero unless the frame checks out.
  always_comb begin
    res.valid                 = v1_r && emit;
    res.item.result_status    = status;
    res.item.distance         = '0;
    res.item.strength         = '0;
    res.item.temperature_code = '0;
    if (status == ST_OK) begin
      res.item.distance         = {body_r[1], body_r[0]};
      res.item.strength         = {body_r[3], body_r[2]};
      res.item.temperature_code = {body_r[5], body_r[4]};
    end
  end

  // The stage moves on unless its result finds the output register full and stalled.
  assign adv      = v1_r && (!emit || res_take);
  assign in_stall = v1_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (adv) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item1_r <= in_data;
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= '0;
      miss_r     <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
      idle_r     <= '0;
    end else if (adv) begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
      miss_r     <= miss_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      idle_r     <= idle_nxt;
    end
  end

  // Body byte store.
  always_ff @(posedge clk) begin
    if (adv && body_we) begin
      body_r[idx_r] <= item1_r.byte_value;
    end
  end

`ifndef SYNTH
  // While hunting, the body index and checksum stay cleared.
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (idx_r == '0 && sum_r == '0))
    else $error("body state not cleared while hunting");

  // The body index never runs past the body.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= BodyIdxW'(BodyLen))
    else $error("body index out of range");

  // A word held back by a full output register stays in the stage.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv) |=> (v1_r && $stable(item1_r)))
    else $error("held input word lost");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rfp_out_reg.sv */
// Output register for result words.
`default_nettype none

module rfp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rfp_pkg::res_t    res,
  output logic                  res_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rfp_pkg::out_item_t    out_data
);
  import rfp_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  // The register can load when empty or when its word leaves this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A result offered while the register can take it shows up next cycle.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_take) |=> out_valid_r)
    else $error("result word dropped");

  // With no result offered, a word that leaves is not replaced.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!res.valid && res_take) |=> !out_valid_r)
    else $error("result word invented");

  // A stalled word keeps its data.
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ranging_frame_parser.sv */
// Top level of the ranging frame parser.
//
//   channel  direction  handshake          word
//   in_      input      valid / stall      mode, byte_value
//   out_     output     valid / stall      result_status, distance, strength,
//                                          temperature_code
//   cfg_     input      valid / ready      register index, write data
//
// One word is taken every cycle while the input does not stall; it is held in
// the input register, and any result it produces is loaded from there into the
// output register, which drives out_valid.
// The input stalls only when a word that produces a result meets a full,
// stalled output register. Reset is synchronous and returns the parser to
// header hunting with default limits.
`default_nettype none

module ranging_frame_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rfp_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rfp_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rfp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [rfp_pkg::CfgDataW-1:0]  cfg_wdata
);
  import rfp_pkg::*;

  res_t res;
  logic res_take;

  // Registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  rfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res_take  (res_take),
    .res       (res)
  );

  rfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
